[hw/rtl/fpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_pkg
// shared constants, types and the quarter-wave sine table
// ----------------------------------------------------------------------------
package fpp_pkg;

    localparam int MAX_HARMONICS = 64;
    localparam int ANGLE_BITS    = 10;
    localparam int QUARTER       = 1 << (ANGLE_BITS - 2);
    localparam int HARM_AW       = $clog2(MAX_HARMONICS);
    localparam int HARM_KW       = $clog2(MAX_HARMONICS + 1);
    localparam int QW_AW         = $clog2(QUARTER + 1);
    localparam int PHASE_BITS    = 40;

    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // function codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PEAK = 2'd1;
    localparam logic [1:0] FUNC_POS  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_HARM_COUNT = 3'd0;
    localparam logic [2:0] REG_INV_PERIOD = 3'd1;
    localparam logic [2:0] REG_INV_RAD_SQ = 3'd2;
    localparam logic [2:0] REG_CENTER_X   = 3'd3;
    localparam logic [2:0] REG_CENTER_Y   = 3'd4;
    localparam logic [2:0] REG_CENTER_Z   = 3'd5;

    localparam logic RESULT_PEAK = 1'b0;
    localparam logic RESULT_POS  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_MEAN,
        ST_H_RD,
        ST_H_MC,
        ST_H_MS,
        ST_H_ACC,
        ST_P_DONE,
        ST_Q_DIFF,
        ST_Q_SQ,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_FAC,
        ST_Q_M1,
        ST_Q_M2,
        ST_Q_OUT
    } t_state;

    typedef logic [31:0] t_qw [0:QUARTER];

    // taylor series for sine in q2.30, horner form
    function automatic t_qw build_qw();
        t_qw         tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int i = 0; i <= QUARTER; i++) begin
            x  = (64'(i) * HALF_PI_Q30) / QUARTER;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd210);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
            t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
            tbl[i] = 32'((x * t) >> 30);
        end
        return tbl;
    endfunction

    localparam t_qw QW_TABLE = build_qw();

    // signed sine of a phase index
    function automatic logic signed [31:0] sine_at(input logic [ANGLE_BITS-1:0] ph);
        logic [1:0]            quad;
        logic [QW_AW-1:0]      off;
        logic [QW_AW-1:0]      idx;
        logic signed [31:0]    mag;
        quad = ph[ANGLE_BITS-1 -: 2];
        off  = QW_AW'(ph[ANGLE_BITS-3:0]);
        idx  = quad[0] ? QW_AW'(QUARTER) - off : off;
        mag  = $signed(QW_TABLE[idx]);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/fourier_pulse_profile.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fourier_pulse_profile
// pulsatile inlet velocity: fourier series peak and parabolic profile
// ----------------------------------------------------------------------------
// an item is taken when i_start is high and o_busy is low. a load item
// (func 0) writes one cosine/sine amplitude pair in the cycle it is taken and
// leaves the block free. a peak item (func 1) keeps o_busy high while it
// works through the clamped harmonic count: every harmonic above the mean
// term passes through the single shared 33x33 multiplier twice (cosine and
// sine products) plus a table read and an accumulate step. a position item
// (func 2) keeps o_busy high through seven multiplier passes in sequence.
// the result is shown on o_velocity/o_result_kind with o_valid high for
// exactly one cycle, the first cycle in which o_busy is low again; the
// receiver cannot stall it, so it must take it then. configuration writes
// apply at once and belong in idle time. amplitude entries never loaded read
// back as undefined values.
// ----------------------------------------------------------------------------
module fourier_pulse_profile
    import fpp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_func,
    input  wire logic [5:0]         i_coef_index,
    input  wire logic signed [31:0] i_cos_amplitude,
    input  wire logic signed [31:0] i_sin_amplitude,
    input  wire logic [31:0]        i_flow_time,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata,
    output logic                    o_valid,
    output logic signed [31:0]      o_velocity,
    output logic                    o_result_kind
);

    // configuration registers
    logic [6:0]         r_harm_count;
    logic [31:0]        r_inv_period;
    logic [31:0]        r_inv_rad_sq;
    logic signed [31:0] r_center [0:2];

    // amplitude memories
    logic signed [31:0] cos_mem [0:MAX_HARMONICS-1];
    logic signed [31:0] sin_mem [0:MAX_HARMONICS-1];
    logic signed [31:0] r_rd_cos;
    logic signed [31:0] r_rd_sin;

    t_state r_state, n_state;

    // working registers
    logic [31:0]                r_time;
    logic signed [31:0]         r_pos [0:2];
    logic [1:0]                 r_axis;
    logic [HARM_KW-1:0]         r_k;
    logic [HARM_KW-1:0]         r_n;
    logic [PHASE_BITS-1:0]      r_base;
    logic [PHASE_BITS-1:0]      r_ph;
    logic signed [31:0]         r_sv;
    logic signed [31:0]         r_cv;
    logic signed [63:0]         r_pc;
    logic signed [63:0]         r_ps;
    logic signed [63:0]         r_acc;
    logic signed [31:0]         r_peak;
    logic [31:0]                r_mabs;
    logic [35:0]                r_r2;
    logic [63:0]                r_plo;
    logic [55:0]                r_ratio;
    logic [55:0]                r_mf;
    logic [31:0]                r_mp;
    logic                       r_neg;
    logic [63:0]                r_p1;
    logic [63:0]                r_mag;

    logic                       r_valid;
    logic signed [31:0]         r_vel;
    logic                       r_kind;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        prod;

    logic               accept;
    logic [HARM_KW-1:0] n_clamp;
    logic signed [32:0] diff;
    logic signed [56:0] factor;
    logic [32:0]        mag_c;
    logic signed [63:0] term;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    // clamp harmonic count to 1 .. MAX_HARMONICS
    always_comb begin
        if (r_harm_count == '0) begin
            n_clamp = HARM_KW'(1);
        end else if (int'(r_harm_count) > MAX_HARMONICS) begin
            n_clamp = HARM_KW'(MAX_HARMONICS);
        end else begin
            n_clamp = HARM_KW'(r_harm_count);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_BASE: begin
                mul_a = $signed({1'b0, r_time});
                mul_b = $signed({1'b0, r_inv_period});
            end
            ST_H_MC: begin
                mul_a = 33'(r_rd_cos);
                mul_b = 33'(r_cv);
            end
            ST_H_MS: begin
                mul_a = 33'(r_rd_sin);
                mul_b = 33'(r_sv);
            end
            ST_Q_SQ: begin
                mul_a = $signed({1'b0, r_mabs});
                mul_b = $signed({1'b0, r_mabs});
            end
            ST_Q_LO: begin
                mul_a = $signed({1'b0, r_r2[31:0]});
                mul_b = $signed({1'b0, r_inv_rad_sq});
            end
            ST_Q_HI: begin
                mul_a = $signed({29'd0, r_r2[35:32]});
                mul_b = $signed({1'b0, r_inv_rad_sq});
            end
            ST_Q_M1: begin
                mul_a = $signed({1'b0, r_mp});
                mul_b = $signed({1'b0, r_mf[55:24]});
            end
            ST_Q_M2: begin
                mul_a = $signed({1'b0, r_mp});
                mul_b = $signed({9'd0, r_mf[23:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = mul_p[63:0];

    // axis difference, absolute value taken below
    assign diff   = 33'(r_pos[r_axis]) - 33'(r_center[r_axis]);
    // 1 - r^2/R^2 in q.24
    assign factor = (57'sd1 <<< 24) - $signed({1'b0, r_ratio});
    // rounded harmonic term
    assign term   = (r_pc - r_ps + (64'sd1 <<< 29)) >>> 30;
    // magnitude clamped to 2^32
    assign mag_c  = (r_mag > (64'd1 << 32)) ? 33'h1_0000_0000 : r_mag[32:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_func == FUNC_PEAK) begin
                    n_state = ST_BASE;
                end else if (accept && i_func == FUNC_POS) begin
                    n_state = ST_Q_DIFF;
                end
            end
            ST_BASE:   n_state = ST_MEAN;
            ST_MEAN:   n_state = (r_k >= r_n) ? ST_P_DONE : ST_H_RD;
            ST_H_RD:   n_state = ST_H_MC;
            ST_H_MC:   n_state = ST_H_MS;
            ST_H_MS:   n_state = ST_H_ACC;
            ST_H_ACC:  n_state = (r_k + 1'b1 >= r_n) ? ST_P_DONE : ST_H_RD;
            ST_P_DONE: n_state = ST_IDLE;
            ST_Q_DIFF: n_state = ST_Q_SQ;
            ST_Q_SQ:   n_state = (r_axis == 2'd2) ? ST_Q_LO : ST_Q_DIFF;
            ST_Q_LO:   n_state = ST_Q_HI;
            ST_Q_HI:   n_state = ST_Q_FAC;
            ST_Q_FAC:  n_state = ST_Q_M1;
            ST_Q_M1:   n_state = ST_Q_M2;
            ST_Q_M2:   n_state = ST_Q_OUT;
            ST_Q_OUT:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harm_count <= 7'd64;
            r_inv_period <= 32'd16777216;
            r_inv_rad_sq <= '0;
            r_center[0]  <= 32'sd4459250;
            r_center[1]  <= -32'sd21539261;
            r_center[2]  <= -32'sd7517267;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_HARM_COUNT: r_harm_count <= i_cfg_wdata[6:0];
                REG_INV_PERIOD: r_inv_period <= i_cfg_wdata;
                REG_INV_RAD_SQ: r_inv_rad_sq <= i_cfg_wdata;
                REG_CENTER_X:   r_center[0]  <= $signed(i_cfg_wdata);
                REG_CENTER_Y:   r_center[1]  <= $signed(i_cfg_wdata);
                REG_CENTER_Z:   r_center[2]  <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // amplitude memories, registered read at the harmonic counter
    always_ff @(posedge i_clk) begin
        if (accept && i_func == FUNC_LOAD && int'(i_coef_index) < MAX_HARMONICS) begin
            cos_mem[HARM_AW'(i_coef_index)] <= i_cos_amplitude;
            sin_mem[HARM_AW'(i_coef_index)] <= i_sin_amplitude;
        end
        r_rd_cos <= cos_mem[r_k[HARM_AW-1:0]];
        r_rd_sin <= sin_mem[r_k[HARM_AW-1:0]];
    end

    // control counters and stored peak
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_axis  <= '0;
            r_peak  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_k    <= '0;
                    r_axis <= '0;
                end
                ST_BASE:  r_k <= HARM_KW'(1);
                ST_H_ACC: r_k <= r_k + 1'b1;
                ST_P_DONE: begin
                    r_peak  <= sat32(r_acc);
                    r_valid <= 1'b1;
                end
                ST_Q_SQ:  r_axis <= r_axis + 2'd1;
                ST_Q_OUT: r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_time   <= i_flow_time;
                r_pos[0] <= i_pos_x;
                r_pos[1] <= i_pos_y;
                r_pos[2] <= i_pos_z;
                r_n      <= n_clamp;
                r_r2     <= '0;
            end
            ST_BASE: begin
                r_base <= prod[PHASE_BITS-1:0];
                r_ph   <= prod[PHASE_BITS-1:0];
            end
            ST_MEAN:  r_acc <= 64'(r_rd_cos);
            ST_H_RD: begin
                // phase of this harmonic picks sine and cosine
                r_sv <= sine_at(r_ph[PHASE_BITS-1 -: ANGLE_BITS]);
                r_cv <= sine_at(r_ph[PHASE_BITS-1 -: ANGLE_BITS]
                                + ANGLE_BITS'(QUARTER));
            end
            ST_H_MC:  r_pc <= $signed(prod);
            ST_H_MS:  r_ps <= $signed(prod);
            ST_H_ACC: begin
                r_acc <= r_acc + term;
                r_ph  <= r_ph + r_base;
            end
            ST_P_DONE: begin
                r_vel  <= sat32(r_acc);
                r_kind <= RESULT_PEAK;
            end
            ST_Q_DIFF: r_mabs <= diff[32] ? 32'(-diff) : diff[31:0];
            ST_Q_SQ:   r_r2   <= r_r2 + 36'(prod[63:30]);
            ST_Q_LO:   r_plo  <= prod;
            ST_Q_HI:   r_ratio <= (56'(prod[37:0]) << 18) + 56'(r_plo >> 14);
            ST_Q_FAC: begin
                r_mf  <= factor[56] ? 56'(-factor) : factor[55:0];
                r_mp  <= r_peak[31] ? 32'(-33'(r_peak)) : r_peak;
                r_neg <= (r_peak > 0 && factor > 0) || (r_peak < 0 && factor < 0);
            end
            ST_Q_M1:  r_p1  <= prod;
            ST_Q_M2:  r_mag <= r_p1 + (prod >> 24);
            ST_Q_OUT: begin
                if (r_neg) begin
                    r_vel <= mag_c[32] || mag_c[31] ? 32'sh80000000
                                                    : -$signed(mag_c[31:0]);
                end else begin
                    r_vel <= mag_c[32] || mag_c[31] ? 32'sh7FFFFFFF
                                                    : $signed(mag_c[31:0]);
                end
                r_kind <= RESULT_POS;
            end
            default: ;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_velocity    = r_vel;
    assign o_result_kind = r_kind;

endmodule
`default_nettype wire

[tb/tb_fourier_pulse_profile.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fourier_pulse_profile
// self-checking bench for the fourier series peak and parabolic profile block
// ----------------------------------------------------------------------------
// a queue of pending items and register writes feeds a clocked driver; a
// bit-exact software copy of the series synthesis and the parabolic profile
// predicts every result, and a clocked monitor compares the strobed results
// in order. all amplitude entries are loaded before the first peak item.
// ----------------------------------------------------------------------------
module tb_fourier_pulse_profile;
    import fpp_pkg::*;

    localparam int  LATE_ITEMS  = 80;        // tail of the run with no gaps
    localparam int  QUIET_NEED  = 8;         // idle cycles before a register write
    localparam int  DRAIN_WAIT  = 400;       // settle time after the last result
    localparam longint CYCLE_LIMIT = 2000000;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_HOLD} t_op;

    typedef struct {
        t_op                op;
        logic [1:0]         func;
        logic [5:0]         coef_index;
        logic signed [31:0] cos_amp;
        logic signed [31:0] sin_amp;
        logic [31:0]        flow_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_val;
    } t_pending;

    typedef struct {
        logic signed [31:0] velocity;
        logic               kind;
    } t_velocity_result;

    // dut ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [1:0]         i_func = '0;
    logic [5:0]         i_coef_index = '0;
    logic signed [31:0] i_cos_amplitude = '0;
    logic signed [31:0] i_sin_amplitude = '0;
    logic [31:0]        i_flow_time = '0;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [31:0] i_pos_z = '0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_wdata = '0;
    logic               o_valid;
    logic signed [31:0] o_velocity;
    logic               o_result_kind;

    fourier_pulse_profile DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_func          (i_func),
        .i_coef_index    (i_coef_index),
        .i_cos_amplitude (i_cos_amplitude),
        .i_sin_amplitude (i_sin_amplitude),
        .i_flow_time     (i_flow_time),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_velocity      (o_velocity),
        .o_result_kind   (o_result_kind)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: amplitude tables, stored peak, registers
    // ------------------------------------------------------------------
    logic signed [31:0] amp_cos [0:MAX_HARMONICS-1];
    logic signed [31:0] amp_sin [0:MAX_HARMONICS-1];
    logic signed [31:0] held_peak = '0;
    logic [6:0]         cfg_harm = 7'd64;
    logic [31:0]        cfg_inv_period = 32'd16777216;
    logic [31:0]        cfg_inv_rad_sq = '0;
    logic signed [31:0] cfg_cx = 32'sd4459250;
    logic signed [31:0] cfg_cy = -32'sd21539261;
    logic signed [31:0] cfg_cz = -32'sd7517267;
    logic [31:0]        sine_quarter [0:QUARTER];

    t_pending           pending_q [$];
    t_velocity_result   velocity_exp_q [$];
    t_pending           cur;

    int  n_loads, n_peaks, n_positions, n_ignored, n_cfg_writes, n_checked;
    int  n_mismatch;
    int  items_left;
    int  gap_cnt;
    int  quiet_cnt;
    longint cycle_cnt;

    // quarter-wave sine in q2.30 from a horner series, sin(pi/2) near 2^30
    task automatic fill_sine_quarter();
        longint unsigned ang, ang2, acc;
        for (int i = 0; i <= QUARTER; i++) begin
            ang  = (longint'(i) * 64'd1686629713) / QUARTER;
            ang2 = (ang * ang) >> 30;
            acc  = 64'd1 << 30;
            for (int n = 14; n >= 2; n -= 2)
                acc = (64'd1 << 30) - ((ang2 * acc) >> 30) / longint'(n * (n + 1));
            sine_quarter[i] = 32'((ang * acc) >> 30);
        end
    endtask

    function automatic longint signed signed_sine(input logic [ANGLE_BITS-1:0] ph);
        logic [1:0]      quad;
        int              off;
        longint signed   mag;
        quad = ph[ANGLE_BITS-1 -: 2];
        off  = int'(ph[ANGLE_BITS-3:0]);
        mag  = quad[0] ? longint'(sine_quarter[QUARTER - off]) : longint'(sine_quarter[off]);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint signed v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // fourier series sum at time t
    function automatic logic signed [31:0] series_peak(input logic [31:0] t);
        int                      terms;
        longint unsigned         base, frac;
        logic [ANGLE_BITS-1:0]   ph;
        longint signed           acc, prod, sv, cv;
        terms = int'(cfg_harm);
        if (terms < 1)
            terms = 1;
        if (terms > MAX_HARMONICS)
            terms = MAX_HARMONICS;
        base = longint'(t) * longint'(cfg_inv_period);
        acc  = longint'(amp_cos[0]);
        for (int k = 1; k < terms; k++) begin
            frac = (longint'(k) * base) & ((64'd1 << 40) - 1);
            ph   = ANGLE_BITS'(frac >> (40 - ANGLE_BITS));
            sv   = signed_sine(ph);
            cv   = signed_sine(ph + ANGLE_BITS'(QUARTER));
            prod = longint'(amp_cos[k]) * cv - longint'(amp_sin[k]) * sv;
            acc  = acc + ((prod + (64'sd1 <<< 29)) >>> 30);
        end
        return clamp32(acc);
    endfunction

    function automatic longint unsigned sq_dist(input logic signed [31:0] p,
                                                input logic signed [31:0] c);
        longint signed   d;
        longint unsigned m;
        d = longint'(p) - longint'(c);
        m = (d < 0) ? longint'(-d) : longint'(d);
        return (m * m) >> 30;       // wraps modulo 2^64 like the block
    endfunction

    // -peak * (1 - r^2/R^2)
    function automatic logic signed [31:0] profile_velocity(input t_pending it);
        longint unsigned r2, plo, phi, ratio, mp, mf, mag;
        longint signed   factor, pk;
        logic            neg;
        r2 = sq_dist(it.pos_x, cfg_cx) + sq_dist(it.pos_y, cfg_cy)
           + sq_dist(it.pos_z, cfg_cz);
        plo    = (r2 & 64'hFFFFFFFF) * longint'(cfg_inv_rad_sq);
        phi    = (r2 >> 32) * longint'(cfg_inv_rad_sq);
        ratio  = (phi << 18) + (plo >> 14);
        factor = longint'(64'd1 << 24) - longint'(ratio);
        pk     = longint'(held_peak);
        mp     = (pk < 0) ? longint'(-pk) : longint'(pk);
        mf     = (factor < 0) ? longint'(-factor) : longint'(factor);
        mag    = mp * (mf >> 24) + ((mp * (mf & 64'hFFFFFF)) >> 24);
        neg    = (pk > 0 && factor > 0) || (pk < 0 && factor < 0);
        if (mag > (64'd1 << 32))
            mag = 64'd1 << 32;
        return clamp32(neg ? -longint'(mag) : longint'(mag));
    endfunction

    // model one accepted item, queue its result if it makes one
    task automatic predict_item(input t_pending it);
        t_velocity_result r;
        case (it.func)
            FUNC_LOAD: begin
                amp_cos[it.coef_index] = it.cos_amp;
                amp_sin[it.coef_index] = it.sin_amp;
                n_loads++;
            end
            FUNC_PEAK: begin
                held_peak  = series_peak(it.flow_time);
                r.velocity = held_peak;
                r.kind     = RESULT_PEAK;
                velocity_exp_q.push_back(r);
                n_peaks++;
            end
            FUNC_POS: begin
                r.velocity = profile_velocity(it);
                r.kind     = RESULT_POS;
                velocity_exp_q.push_back(r);
                n_positions++;
            end
            default: n_ignored++;
        endcase
    endtask

    task automatic apply_cfg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_HARM_COUNT: cfg_harm       = val[6:0];
            REG_INV_PERIOD: cfg_inv_period = val;
            REG_INV_RAD_SQ: cfg_inv_rad_sq = val;
            REG_CENTER_X:   cfg_cx         = val;
            REG_CENTER_Y:   cfg_cy         = val;
            REG_CENTER_Z:   cfg_cz         = val;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic t_pending blank_item(input logic [1:0] f);
        t_pending it;
        it.op         = OP_ITEM;
        it.func       = f;
        it.coef_index = 6'($urandom);
        it.cos_amp    = $urandom;
        it.sin_amp    = $urandom;
        it.flow_time  = $urandom;
        it.pos_x      = $urandom;
        it.pos_y      = $urandom;
        it.pos_z      = $urandom;
        it.reg_idx    = REG_HARM_COUNT;
        it.reg_val    = '0;
        return it;
    endfunction

    task automatic push_load(input int idx, input logic [31:0] c, input logic [31:0] s);
        t_pending it;
        it = blank_item(FUNC_LOAD);
        it.coef_index = 6'(idx);
        it.cos_amp    = c;
        it.sin_amp    = s;
        pending_q.push_back(it);
    endtask

    task automatic push_peak(input logic [31:0] t);
        t_pending it;
        it = blank_item(FUNC_PEAK);
        it.flow_time = t;
        pending_q.push_back(it);
    endtask

    task automatic push_pos(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        t_pending it;
        it = blank_item(FUNC_POS);
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        pending_q.push_back(it);
    endtask

    task automatic push_cfg(input logic [2:0] idx, input logic [31:0] val);
        t_pending it;
        it = blank_item(FUNC_LOAD);
        it.op      = OP_CFG;
        it.reg_idx = idx;
        it.reg_val = val;
        pending_q.push_back(it);
    endtask

    task automatic push_hold();
        t_pending it;
        it = blank_item(FUNC_LOAD);
        it.op = OP_HOLD;
        pending_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_amp();
        // mostly moderate amplitudes so the sum does not always saturate
        if ($urandom_range(0, 3) != 0)
            return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
        return $urandom;
    endfunction

    function automatic logic [31:0] near_center(input logic signed [31:0] c);
        return c + 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
    endfunction

    // random register setting for one phase of the run
    task automatic push_phase_cfg();
        logic [31:0] rad;
        case ($urandom_range(0, 5))
            0:       push_cfg(REG_HARM_COUNT, 32'($urandom_range(0, 127)));
            1:       push_cfg(REG_HARM_COUNT, 32'd64);
            default: push_cfg(REG_HARM_COUNT, 32'($urandom_range(1, 12)));
        endcase
        push_cfg(REG_INV_PERIOD, ($urandom_range(0, 1) != 0) ? $urandom
                                                             : 32'($urandom_range(0, 1 << 26)));
        // a radius scale, mostly small, that keeps the ratio below one for points near the centre
        rad = ($urandom_range(0, 2) != 0) ? 32'($urandom_range(1 << 8, 1 << 16)) : $urandom;
        push_cfg(REG_INV_RAD_SQ, rad);
        push_cfg(REG_CENTER_X, ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 1 << 24)));
        push_cfg(REG_CENTER_Y, $urandom);
        push_cfg(REG_CENTER_Z, $urandom);
    endtask

    // ------------------------------------------------------------------
    // driver: one item or register write at a time from the pending queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic     nxt_start;
        logic     nxt_wr;
        t_pending head;
        nxt_start = 1'b0;
        nxt_wr    = 1'b0;
        if (!i_rst_n) begin
            gap_cnt   <= 0;
            quiet_cnt <= 0;
        end else begin
            if (velocity_exp_q.size() == 0 && !o_busy && !i_start && !o_valid)
                quiet_cnt <= quiet_cnt + 1;
            else
                quiet_cnt <= 0;
            if (i_start && !o_busy)
                predict_item(cur);
            if (i_start && o_busy) begin
                nxt_start = 1'b1;      // still waiting for acceptance
            end else if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
            end else if (pending_q.size() > 0) begin
                head = pending_q[0];
                case (head.op)
                    OP_ITEM: begin
                        cur = pending_q.pop_front();
                        items_left--;
                        nxt_start        = 1'b1;
                        i_func          <= head.func;
                        i_coef_index    <= head.coef_index;
                        i_cos_amplitude <= head.cos_amp;
                        i_sin_amplitude <= head.sin_amp;
                        i_flow_time     <= head.flow_time;
                        i_pos_x         <= head.pos_x;
                        i_pos_y         <= head.pos_y;
                        i_pos_z         <= head.pos_z;
                        // random idle bursts, none near the end
                        if (items_left > LATE_ITEMS && $urandom_range(0, 4) == 0)
                            gap_cnt <= $urandom_range(1, 12);
                    end
                    OP_CFG: begin
                        // registers change only once the block has gone quiet
                        if (quiet_cnt >= QUIET_NEED) begin
                            void'(pending_q.pop_front());
                            nxt_wr       = 1'b1;
                            i_cfg_index <= head.reg_idx;
                            i_cfg_wdata <= head.reg_val;
                            apply_cfg(head.reg_idx, head.reg_val);
                        end
                    end
                    default: begin
                        // sender pause until everything has come back
                        if (velocity_exp_q.size() == 0 && !o_busy)
                            void'(pending_q.pop_front());
                    end
                endcase
            end
        end
        i_start     <= nxt_start;
        i_cfg_wr_en <= nxt_wr;
    end

    // ------------------------------------------------------------------
    // monitor: every strobed result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_velocity_result want;
        if (i_rst_n && o_valid) begin
            if (velocity_exp_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result: velocity %0d kind %0d", o_velocity,
                             o_result_kind);
            end else begin
                want = velocity_exp_q.pop_front();
                n_checked++;
                if (o_velocity !== want.velocity || o_result_kind !== want.kind) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: velocity exp %0d got %0d, kind exp %0d got %0d",
                                 want.velocity, o_velocity, want.kind, o_result_kind);
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int wait_cycles;
        n_loads = 0; n_peaks = 0; n_positions = 0; n_ignored = 0;
        n_cfg_writes = 0; n_checked = 0; n_mismatch = 0;
        gap_cnt = 0; quiet_cnt = 0; cycle_cnt = 0;
        for (int i = 0; i < MAX_HARMONICS; i++) begin
            amp_cos[i] = '0;
            amp_sin[i] = '0;
        end
        fill_sine_quarter();

        // directed: a position item before any peak sees a zero peak
        push_pos(32'sh7FFFFFFF, 32'sh80000000, 32'd0);
        // fill every amplitude entry, extremes in the first few
        push_load(0, 32'sh7FFFFFFF, 32'sh80000000);
        push_load(1, 32'sh80000000, 32'sh7FFFFFFF);
        push_load(2, 32'hFFFFFFFF, 32'd0);
        for (int i = 3; i < MAX_HARMONICS; i++)
            push_load(i, rand_amp(), rand_amp());
        // peak at the time extremes, with and without saturation
        push_peak(32'd0);
        push_peak(32'hFFFFFFFF);
        push_pos(32'd4459250, -32'sd21539261, -32'sd7517267);
        push_load(0, 32'd1 << 24, 32'd0);
        push_load(1, 32'd1 << 22, 32'd1 << 21);
        push_load(2, 32'd0, 32'd0);
        push_peak(32'h00008000);
        // unknown func is dropped
        pending_q.push_back(blank_item(2'd3));
        // register extremes: mean term only, wrapping phases, huge radius scale
        push_hold();
        push_cfg(REG_HARM_COUNT, 32'd0);
        push_cfg(REG_INV_PERIOD, 32'hFFFFFFFF);
        push_cfg(REG_INV_RAD_SQ, 32'hFFFFFFFF);
        push_cfg(REG_CENTER_X, 32'sh80000000);
        push_cfg(REG_CENTER_Y, 32'sh7FFFFFFF);
        push_cfg(REG_CENTER_Z, 32'd0);
        push_peak(32'hFFFFFFFF);
        push_pos(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        push_pos(32'sh80000000, 32'sh7FFFFFFF, 32'd0);
        push_cfg(REG_HARM_COUNT, 32'd127);
        push_cfg(REG_INV_PERIOD, 32'd0);
        push_cfg(REG_INV_RAD_SQ, 32'd0);
        push_peak(32'h12345678);
        push_pos($urandom, $urandom, $urandom);
        push_cfg(REG_HARM_COUNT, 32'd1);
        push_cfg(REG_INV_PERIOD, 32'd1 << 24);
        push_peak(32'd3 << 15);

        // random phases: new registers, then a mix of loads and evaluations
        for (int phase_no = 0; phase_no < 7; phase_no++) begin
            push_hold();
            push_phase_cfg();
            for (int n = 0; n < 95; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    push_load($urandom_range(0, 63), rand_amp(), rand_amp());
                else if (pick < 60)
                    push_peak($urandom);
                else if (pick < 95)
                    push_pos(($urandom_range(0, 1) != 0) ? near_center(cfg_cx) : $urandom,
                             $urandom, $urandom);
                else
                    pending_q.push_back(blank_item(2'd3));
                if (n == 50 && phase_no == 3)
                    push_hold();
            end
        end
        items_left = 0;
        foreach (pending_q[i])
            if (pending_q[i].op == OP_ITEM)
                items_left++;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0);
        @(posedge i_clk);
        wait_cycles = 0;
        while (velocity_exp_q.size() != 0 || i_start) begin
            @(posedge i_clk);
        end
        while (wait_cycles < DRAIN_WAIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("covered %0d loads, %0d peak and %0d position items, %0d dropped items",
                 n_loads, n_peaks, n_positions, n_ignored);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 n_cfg_writes, n_checked, n_mismatch);
        if (n_mismatch == 0 && velocity_exp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
